// ===== sv/morton_code_point_sorter_assert.svh =====
// ----------------------------------------------------------------------------
// Morton point sorter assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef MORTON_CODE_POINT_SORTER_ASSERT_SVH
`define MORTON_CODE_POINT_SORTER_ASSERT_SVH
`ifndef SYNTHESIS
`define MCPS_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define MCPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MCPS_ASSERT_NOW(lbl, clk, rstn, prop, msg)
`define MCPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/mcps_pkg.sv =====
// ----------------------------------------------------------------------------
// Morton point sorter package
// Widths, queue sizing, point record type and Morton key functions.
// ----------------------------------------------------------------------------
package mcps_pkg;

    localparam int COORD_W        = 32;
    localparam int GRID_W         = 10;
    localparam int KEY_W          = 3 * GRID_W;
    localparam int MAX_POINTS_DEF = 64;
    localparam int Q_DEPTH        = 2;
    localparam int Q_AW           = $clog2(Q_DEPTH);
    localparam int Q_CW           = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [KEY_W-1:0]   key;
        logic                      final_point;
    } point_t;

    // Q16.16 -> 0..1023 grid index: clamp negatives, saturate at 1.0
    function automatic logic [GRID_W-1:0] grid_f(input logic signed [COORD_W-1:0] raw);
        logic [GRID_W-1:0] g;
        if (raw[COORD_W-1]) begin
            g = '0;
        end else if (|raw[COORD_W-2:16]) begin
            g = '1;
        end else begin
            g = raw[15:6];
        end
        return g;
    endfunction

    function automatic logic [KEY_W-1:0] morton_f(input logic signed [COORD_W-1:0] x,
                                                  input logic signed [COORD_W-1:0] y,
                                                  input logic signed [COORD_W-1:0] z);
        logic [GRID_W-1:0] gx;
        logic [GRID_W-1:0] gy;
        logic [GRID_W-1:0] gz;
        logic [KEY_W-1:0]  k;
        gx = grid_f(x);
        gy = grid_f(y);
        gz = grid_f(z);
        for (int i = 0; i < GRID_W; i++) begin
            k[3*i+2] = gx[i];
            k[3*i+1] = gy[i];
            k[3*i]   = gz[i];
        end
        return k;
    endfunction

endpackage

// ===== sv/mcps_ram.sv =====
// ----------------------------------------------------------------------------
// Morton point sorter generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mcps_front.sv =====
// ----------------------------------------------------------------------------
// Morton point sorter front end
// Takes input beats and tags each point with its 30-bit Morton key.
// ----------------------------------------------------------------------------
module mcps_front (
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mcps_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [mcps_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [mcps_pkg::COORD_W-1:0] s_coord_z,
    input  logic                                s_final_point,
    output logic                                pt_valid,
    input  logic                                pt_ready,
    output mcps_pkg::point_t                    pt_data
);
    import mcps_pkg::*;

    always_comb begin
        pt_data.x           = s_coord_x;
        pt_data.y           = s_coord_y;
        pt_data.z           = s_coord_z;
        pt_data.key         = morton_f(s_coord_x, s_coord_y, s_coord_z);
        pt_data.final_point = s_final_point;
    end

    assign pt_valid = s_valid;
    assign s_ready  = pt_ready;

endmodule

// ===== sv/mcps_queue.sv =====
// ----------------------------------------------------------------------------
// Morton point sorter point queue
// Short FIFO that decouples the front end from the sorter.
// ----------------------------------------------------------------------------
module mcps_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mcps_pkg::point_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mcps_pkg::point_t out_data
);
    import mcps_pkg::*;

    point_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready  = (cnt_reg != Q_CW'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== sv/mcps_sorter.sv =====
// ----------------------------------------------------------------------------
// Morton point sorter back end
// Insertion cell chain of keys and slot indices; coordinates live in a RAM.
// Drains the set in ascending key order, equal keys in arrival order.
// ----------------------------------------------------------------------------
`include "morton_code_point_sorter_assert.svh"

module mcps_sorter #(
    parameter int MAX_POINTS = mcps_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  mcps_pkg::point_t                    q_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcps_pkg::COORD_W-1:0] m_out_x,
    output logic signed [mcps_pkg::COORD_W-1:0] m_out_y,
    output logic signed [mcps_pkg::COORD_W-1:0] m_out_z,
    output logic        [mcps_pkg::KEY_W-1:0]   m_morton_key,
    output logic                                m_end_of_run,
    output logic                                m_overflowed
);
    import mcps_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int RAMW = 3 * COORD_W;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_READ = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [KEY_W-1:0]  cell_key_reg [MAX_POINTS];
    logic [KEY_W-1:0]  cell_key_next [MAX_POINTS];
    logic [AW-1:0]     cell_idx_reg [MAX_POINTS];
    logic [AW-1:0]     cell_idx_next [MAX_POINTS];
    logic [MAX_POINTS-1:0] gt;

    logic              m_valid_reg, m_valid_next;
    logic signed [COORD_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    logic [KEY_W-1:0]  m_key_reg;
    logic              m_end_reg, m_ovf_reg;

    logic              pop, full, ins, shift;
    logic [RAMW-1:0]   ram_rdata;

    assign q_ready = (state_reg == ST_LOAD);
    assign pop     = q_valid && q_ready;
    assign full    = (count_reg == CW'(MAX_POINTS));
    assign ins     = pop && !full;
    assign shift   = (state_reg == ST_WAIT);

    mcps_ram #(
        .WIDTH(RAMW),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ins),
        .waddr(count_reg[AW-1:0]),
        .wdata({q_data.x, q_data.y, q_data.z}),
        .raddr(cell_idx_reg[0]),
        .rdata(ram_rdata)
    );

    // strictly greater keys move right so equal keys keep arrival order
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            gt[i] = (CW'(i) >= count_reg) || (cell_key_reg[i] > q_data.key);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            cell_key_next[i] = cell_key_reg[i];
            cell_idx_next[i] = cell_idx_reg[i];
        end
        if (ins) begin
            if (gt[0]) begin
                cell_key_next[0] = q_data.key;
                cell_idx_next[0] = count_reg[AW-1:0];
            end
            for (int i = 1; i < MAX_POINTS; i++) begin
                if (gt[i] && !gt[i-1]) begin
                    cell_key_next[i] = q_data.key;
                    cell_idx_next[i] = count_reg[AW-1:0];
                end else if (gt[i]) begin
                    cell_key_next[i] = cell_key_reg[i-1];
                    cell_idx_next[i] = cell_idx_reg[i-1];
                end
            end
        end else if (shift) begin
            for (int i = 0; i < MAX_POINTS - 1; i++) begin
                cell_key_next[i] = cell_key_reg[i+1];
                cell_idx_next[i] = cell_idx_reg[i+1];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_LOAD: begin
                if (pop) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                    if (q_data.final_point) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                count_next   = count_reg - 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_end_reg) begin
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            cell_key_reg[i] <= cell_key_next[i];
            cell_idx_reg[i] <= cell_idx_next[i];
        end
        if (shift) begin
            m_x_reg   <= ram_rdata[3*COORD_W-1:2*COORD_W];
            m_y_reg   <= ram_rdata[2*COORD_W-1:COORD_W];
            m_z_reg   <= ram_rdata[COORD_W-1:0];
            m_key_reg <= cell_key_reg[0];
            m_end_reg <= (count_reg == CW'(1));
            m_ovf_reg <= drop_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = m_x_reg;
    assign m_out_y      = m_y_reg;
    assign m_out_z      = m_z_reg;
    assign m_morton_key = m_key_reg;
    assign m_end_of_run = m_end_reg;
    assign m_overflowed = m_ovf_reg;

    `MCPS_ASSERT_NOW(a_valid_in_out, aclk, aresetn, m_valid_reg == (state_reg == ST_OUT), "output beat outside drain state")
    `MCPS_ASSERT_NEXT(a_drop_flag, aclk, aresetn, pop && full, drop_reg, "dropped point not flagged")
    `MCPS_ASSERT_NEXT(a_run_empty, aclk, aresetn, m_valid_reg && m_ready && m_end_reg, (count_reg == '0) && !drop_reg, "set not emptied after last beat")

endmodule

// ===== sv/morton_code_point_sorter.sv =====
// ----------------------------------------------------------------------------
// Morton code point sorter
// Collects Q16.16 3D points, keys them by 30-bit Morton code and emits the
// set in ascending key order once the final point arrives.
// ----------------------------------------------------------------------------
// Channel | Direction | Beat contents
// s_      | in        | s_coord_x/y/z, s_final_point
// m_      | out       | m_out_x/y/z, m_morton_key, m_end_of_run, m_overflowed
//
// Load: one point per cycle into the insertion cell chain.
// Drain: each result steps through ST_READ, ST_WAIT for the coordinate RAM read, and ST_OUT until taken.
// A two-beat queue takes up to two input points while the sorter drains.
// Reset is synchronous; no clearing pass, every read slot was written first.
// Points beyond MAX_POINTS are dropped and flag the whole set.
// ----------------------------------------------------------------------------
module morton_code_point_sorter #(
    parameter int MAX_POINTS = mcps_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mcps_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [mcps_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [mcps_pkg::COORD_W-1:0] s_coord_z,
    input  logic                                s_final_point,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcps_pkg::COORD_W-1:0] m_out_x,
    output logic signed [mcps_pkg::COORD_W-1:0] m_out_y,
    output logic signed [mcps_pkg::COORD_W-1:0] m_out_z,
    output logic        [mcps_pkg::KEY_W-1:0]   m_morton_key,
    output logic                                m_end_of_run,
    output logic                                m_overflowed
);
    import mcps_pkg::*;

    logic   pt_valid, pt_ready;
    point_t pt_data;
    logic   q_valid, q_ready;
    point_t q_data;

    mcps_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coord_x    (s_coord_x),
        .s_coord_y    (s_coord_y),
        .s_coord_z    (s_coord_z),
        .s_final_point(s_final_point),
        .pt_valid     (pt_valid),
        .pt_ready     (pt_ready),
        .pt_data      (pt_data)
    );

    mcps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pt_valid),
        .in_ready (pt_ready),
        .in_data  (pt_data),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    mcps_sorter #(
        .MAX_POINTS(MAX_POINTS)
    ) u_sorter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_morton_key(m_morton_key),
        .m_end_of_run(m_end_of_run),
        .m_overflowed(m_overflowed)
    );

endmodule
